// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ETSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check on every clock edge, reset included
`define ETSP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- hdl/etsp_pkg.sv -----
// Types, constants and helper functions of the smooth escape-time pixel colouring block
package etsp_pkg;

   typedef struct packed {
      logic signed [31:0] z_re;
      logic signed [31:0] z_im;
      logic signed [47:0] dz_re;
      logic signed [47:0] dz_im;
      logic [15:0]        iteration_count;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rsp_type;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_SCALE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_INTENSITY = 1'b1;

   localparam logic [63:0]        PIXEL_SCALE_RST     = 64'h1000_0000_0000_0000;
   localparam logic signed [15:0] COLOR_INTENSITY_RST = 16'shFDF6;

   localparam int LATENCY = 62;

   localparam logic signed [25:0] ONE_Q     = 26'sd16777216;
   localparam logic signed [41:0] HALF_Q    = 42'sd8388608;
   localparam logic signed [31:0] LOG_MIN   = 32'sh8000_0000;
   localparam logic signed [24:0] LN2_Q     = 25'sd11629080;
   localparam logic signed [25:0] INV_LNP_Q = 26'sd16780779;
   localparam logic signed [28:0] LLE_Q     = 29'sd131650814;
   localparam logic signed [26:0] OFFSET_Q  = 27'sd20132659;
   localparam logic signed [39:0] DS_FLOOR  = -40'sd134217728;
   localparam logic [23:0]        BAND_V_Q  = 24'd14260634;
   localparam logic [23:0]        BAND_R_Q  = 24'd11190403;

   // log2(1 + k/2^b) in Q1.24 by repeated squaring
   function automatic logic [24:0] log_entry(input int k, input int b);
      logic [63:0] x;
      logic [24:0] v;
      x = (64'd1 << 30) + (64'(k) << (30 - b));
      v = '0;
      if (k == (1 << b)) begin
         v = 25'd1 << 24;
      end else begin
         for (int i = 23; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               v[i] = 1'b1;
               x = x >> 1;
            end
         end
      end
      return v;
   endfunction

   function automatic logic [5:0] msb64(input logic [63:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

endpackage

// ----- hdl/etsp_log2.sv -----
// Four-stage fixed-point log2 unit with table interpolation, result in Q.24
module etsp_log2 #(
   parameter int TABLE_BITS = 8,
   parameter int FRAC_BITS  = 24
) (
   input  logic               clock,
   input  logic [63:0]        x,
   output logic signed [31:0] y
);

   localparam int TAB_N = 1 << TABLE_BITS;

   logic [24:0] tab [0:TAB_N];

   for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
      localparam logic [24:0] ENTRY = etsp_pkg::log_entry(k, TABLE_BITS);
      assign tab[k] = ENTRY;
   end

   logic [63:0]           x1_ff;
   logic [5:0]            p1_ff, p2_ff, p3_ff;
   logic                  z1_ff, z2_ff, z3_ff;
   logic [TABLE_BITS-1:0] idx2_ff, idx2_in;
   logic [23:0]           rem2_ff, rem2_in, rem3_ff;
   logic [24:0]           lo3_ff, lo3_in, d3_ff, d3_in;
   logic signed [31:0]    y_ff, y_in;
   logic [63:0]           mant;
   logic [TABLE_BITS:0]   lo_idx, hi_idx;
   logic [24:0]           hi_val;
   logic [48:0]           prod;
   logic [24:0]           fr;
   logic signed [7:0]     expo;

   always_comb begin
      mant    = (x1_ff << (6'd63 - p1_ff)) << 1;
      idx2_in = mant[63 -: TABLE_BITS];
      rem2_in = mant[63-TABLE_BITS -: 24];

      lo_idx  = {1'b0, idx2_ff};
      hi_idx  = lo_idx + 1'b1;
      lo3_in  = tab[lo_idx];
      hi_val  = tab[hi_idx];
      d3_in   = (hi_val > lo3_in) ? hi_val - lo3_in : '0;

      prod    = 49'(d3_ff) * 49'(rem3_ff);
      fr      = lo3_ff + 25'(prod >> 24);
      expo    = 8'(p3_ff) - 8'(FRAC_BITS);
      y_in    = z3_ff ? etsp_pkg::LOG_MIN : $signed({expo, 24'd0}) + $signed(32'(fr));
   end

   always_ff @(posedge clock) begin
      x1_ff   <= x;
      p1_ff   <= etsp_pkg::msb64(x);
      z1_ff   <= (x == '0);
      idx2_ff <= idx2_in;
      rem2_ff <= rem2_in;
      p2_ff   <= p1_ff;
      z2_ff   <= z1_ff;
      lo3_ff  <= lo3_in;
      d3_ff   <= d3_in;
      rem3_ff <= rem2_ff;
      p3_ff   <= p2_ff;
      z3_ff   <= z2_ff;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule

// ----- hdl/escape_time_smooth_pixel_color.sv -----
// Top level of the smooth escape-time pixel colouring pipeline
//
// One pixel beat enters on req_data at each clock edge where start is high
// and busy is low; busy is high only in the cycle after a reset cycle, so a
// pixel may enter on every clock. Each pixel gives one colour beat on
// rsp_data, marked by rsp_valid for exactly one cycle, in input order.
// Throughput is one pixel per cycle. The depth is set by three chained log2
// units (four stages each) and the 32-stage square root that forms the
// saturation radius. csr_we writes pixel_scale (index 0) or color_intensity
// (index 1) from csr_wdata; both registers are sampled as a pixel enters.
// Reset clears all valid bits, dropping pixels in flight, and restores the
// register defaults. The receiver cannot stall: rsp_valid is a strobe and
// the pipeline never holds.
module escape_time_smooth_pixel_color #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  etsp_pkg::pixel_req_type              req_data,
   output logic                                 rsp_valid,
   output etsp_pkg::pixel_rsp_type              rsp_data,
   input  logic                                 csr_we,
   input  logic [etsp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                          csr_wdata
);

   localparam int LAST      = etsp_pkg::LATENCY - 1;
   localparam int SIDE_LAST = 55;
   localparam int SQ_STEPS  = 32;

   typedef struct packed {
      logic [15:0]        n;
      logic [16:0]        aci;
      logic               ci_pos;
      logic               dz_nz;
      logic [4:0]         sh;
      logic signed [31:0] lps;
      logic signed [31:0] l2z;
      logic               lnz_pos;
      logic signed [31:0] l2dz;
      logic signed [31:0] l2lnz;
      logic signed [35:0] ratio;
      logic signed [33:0] t;
      logic signed [39:0] ds;
      logic signed [43:0] dwell;
      logic [24:0]        val;
      logic signed [31:0] lnd;
      logic signed [39:0] qa;
      logic [23:0]        angle;
   } side_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s, input int j);
      sqrt_type   o;
      logic [63:0] b;
      b = 64'd1 << (64 - 2 * j);
      if (s.v >= s.r + b) begin
         o.v = s.v - (s.r + b);
         o.r = (s.r >> 1) + b;
      end else begin
         o.v = s.v;
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   logic [63:0]        ps_ff;
   logic signed [15:0] ci_ff;
   logic               busy_ff;
   logic               vld_ff [0:LAST];

   etsp_pkg::pixel_req_type req_ff;
   logic [63:0]  ps0_ff;
   logic [31:0]  azr1_ff, azi1_ff, azr1_in, azi1_in;
   logic [47:0]  adr1_ff, adi1_ff, adr1_in, adi1_in, adr2_ff, adi2_ff;
   logic [63:0]  zr2_ff, zi2_ff, z2_3_ff;
   logic [5:0]   pd2_ff;
   logic [4:0]   sh_c;
   logic [30:0]  adr3_ff, adi3_ff;
   logic [61:0]  dr4_ff, di4_ff;
   logic [62:0]  d2_5_ff;
   logic signed [31:0] lnz9_ff, lnz9_in;
   logic [63:0]  logb_x;
   logic [42:0]  adw16_ff, adw16_in;
   logic signed [31:0] loga_y, logb_y, logc_y, logd_y, loge_y;

   side_type side_ff [0:SIDE_LAST];
   side_type side_in [0:SIDE_LAST];
   sqrt_type sq_ff [0:SQ_STEPS];
   sqrt_type sq_in [0:SQ_STEPS];

   logic signed [56:0] lnz_prod, lnd_prod;
   logic signed [57:0] t_prod;
   logic signed [61:0] ds_prod;
   logic signed [49:0] qa_prod;
   logic signed [41:0] three, ang, qs;
   logic signed [15:0] ci_neg;

   logic [24:0] val56_ff, val56_in, val57_ff, val58_ff, val59_ff;
   logic [29:0] rad56;
   logic [23:0] sat56_ff, sat57_ff, hfrac56_ff, hfrac56_in;
   logic        band;
   logic [26:0] six;
   logic [2:0]  sec57_ff, sec58_ff, sec59_ff;
   logic [23:0] f57_ff;
   logic        satz58_ff, satz59_ff;
   logic [23:0] sf58_ff, sf58_in, sf1_58_ff, sf1_58_in;
   logic [24:0] pq58_ff, pq58_in, pq59_ff, qq59_ff, qq59_in, tt59_ff, tt59_in;
   logic [24:0] cr60_ff, cg60_ff, cb60_ff, cr60_in, cg60_in, cb60_in;
   etsp_pkg::pixel_rsp_type rsp_ff, rsp_in;

   etsp_log2 #(.TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(60)) u_log_ps (
      .clock(clock), .x(ps0_ff), .y(loge_y));
   etsp_log2 #(.TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(48)) u_log_z (
      .clock(clock), .x(z2_3_ff), .y(loga_y));
   etsp_log2 #(.TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(48)) u_log_dz (
      .clock(clock), .x(64'(d2_5_ff)), .y(logd_y));
   etsp_log2 #(.TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(24)) u_log_lnz (
      .clock(clock), .x(logb_x), .y(logb_y));
   etsp_log2 #(.TABLE_BITS(LOG_TABLE_BITS), .FRAC_BITS(24)) u_log_dwell (
      .clock(clock), .x(64'(adw16_ff)), .y(logc_y));

   always_comb begin
      azr1_in = req_ff.z_re[31] ? ~req_ff.z_re + 1'b1 : req_ff.z_re;
      azi1_in = req_ff.z_im[31] ? ~req_ff.z_im + 1'b1 : req_ff.z_im;
      adr1_in = req_ff.dz_re[47] ? ~req_ff.dz_re + 1'b1 : req_ff.dz_re;
      adi1_in = req_ff.dz_im[47] ? ~req_ff.dz_im + 1'b1 : req_ff.dz_im;
      sh_c    = (pd2_ff > 6'd30) ? 5'(pd2_ff - 6'd30) : 5'd0;
      ci_neg  = -ci_ff;

      lnz_prod = 57'(side_ff[8].l2z) * 57'(etsp_pkg::LN2_Q);
      lnz9_in  = 32'(lnz_prod >>> 24);
      logb_x   = (lnz9_ff > 0) ? 64'(lnz9_ff) : '0;

      t_prod   = 58'(logb_y) * 58'(etsp_pkg::INV_LNP_Q);
      ds_prod  = 62'(side_ff[14].ratio) * 62'(etsp_pkg::INV_LNP_Q);
      adw16_in = side_ff[15].dwell[43] ? 43'(-side_ff[15].dwell) : 43'(side_ff[15].dwell);
      lnd_prod = 57'(logc_y) * 57'(etsp_pkg::LN2_Q);
      qa_prod  = 50'(side_ff[21].lnd) * 50'($signed({1'b0, side_ff[21].aci}));

      three = 42'(side_ff[22].qa) * 42'sd3;
      if (42'(side_ff[22].qa) < etsp_pkg::HALF_Q) begin
         ang = three >>> 1;
         qs  = 42'(etsp_pkg::ONE_Q) - ang;
      end else begin
         qs  = (three >>> 1) - etsp_pkg::HALF_Q;
         ang = qs;
      end

      for (int k = 0; k <= SIDE_LAST; k++) begin
         side_in[k] = (k == 0) ? '0 : side_ff[k-1];
      end
      side_in[0].n      = req_data.iteration_count;
      side_in[0].aci    = ci_ff[15] ? 17'(ci_neg) : 17'(ci_ff);
      side_in[0].ci_pos = (ci_ff > 0);
      if (ci_ff == 16'sh8000) begin
         side_in[0].aci = 17'd32768;
      end
      side_in[1].dz_nz  = (|req_ff.dz_re) | (|req_ff.dz_im);
      side_in[3].sh     = sh_c;
      side_in[5].lps    = loge_y;
      side_in[8].l2z    = loga_y >>> 1;
      side_in[10].lnz_pos = (lnz9_ff > 0);
      side_in[10].l2dz  = (logd_y >>> 1) + $signed({3'd0, side_ff[9].sh, 24'd0});
      side_in[14].l2lnz = logb_y;
      side_in[14].ratio = 36'(etsp_pkg::ONE_Q) + 36'(side_ff[13].l2z) + 36'(logb_y)
                          - 36'(side_ff[13].l2dz) - 36'(side_ff[13].lps);
      side_in[14].t     = 34'(t_prod >>> 24);
      side_in[15].ds    = 40'(ds_prod >>> 24) - 40'(etsp_pkg::OFFSET_Q);
      side_in[15].dwell = $signed(44'({side_ff[14].n, 24'd0})) - 44'(side_ff[14].t)
                          + 44'(etsp_pkg::LLE_Q);
      if (!side_ff[15].dz_nz) begin
         side_in[16].val = 25'd1 << 24;
      end else if (!side_ff[15].lnz_pos) begin
         side_in[16].val = '0;
      end else if (side_ff[15].ds < etsp_pkg::DS_FLOOR) begin
         side_in[16].val = '0;
      end else if (side_ff[15].ds[39]) begin
         side_in[16].val = 25'(40'(etsp_pkg::ONE_Q) + (side_ff[15].ds >>> 3));
      end else begin
         side_in[16].val = 25'd1 << 24;
      end
      side_in[21].lnd   = 32'(lnd_prod >>> 24);
      side_in[22].qa    = 40'(qa_prod >>> 12);
      side_in[23].angle = ang[23:0];

      sq_in[0].v = {qs[35:0], 24'd0} + 64'd0;
      sq_in[0].r = '0;
      for (int j = 1; j <= SQ_STEPS; j++) begin
         sq_in[j] = sqrt_step(sq_ff[j-1], j);
      end

      band       = side_ff[SIDE_LAST].n[0] & side_ff[SIDE_LAST].ci_pos;
      rad56      = sq_ff[SQ_STEPS].r[29:0];
      val56_in   = side_ff[SIDE_LAST].val;
      if (band) begin
         val56_in = 25'((49'(side_ff[SIDE_LAST].val) * 49'(etsp_pkg::BAND_V_Q)) >> 24);
         rad56    = 30'((54'(sq_ff[SQ_STEPS].r[29:0]) * 54'(etsp_pkg::BAND_R_Q)) >> 24);
      end
      hfrac56_in = 24'(28'(side_ff[SIDE_LAST].angle) * 28'd10);

      six = 27'(hfrac56_ff) * 27'd6;

      sf58_in   = 24'((48'(sat57_ff) * 48'(f57_ff)) >> 24);
      sf1_58_in = 24'((49'(sat57_ff) * 49'((25'd1 << 24) - 25'(f57_ff))) >> 24);
      pq58_in   = 25'((50'(val57_ff) * 50'((25'd1 << 24) - 25'(sat57_ff))) >> 24);

      qq59_in = 25'((50'(val58_ff) * 50'((25'd1 << 24) - 25'(sf58_ff))) >> 24);
      tt59_in = 25'((50'(val58_ff) * 50'((25'd1 << 24) - 25'(sf1_58_ff))) >> 24);

      if (satz59_ff) begin
         cr60_in = val59_ff;
         cg60_in = val59_ff;
         cb60_in = val59_ff;
      end else begin
         case (sec59_ff)
            3'd0: begin
               cr60_in = val59_ff; cg60_in = tt59_ff;  cb60_in = pq59_ff;
            end
            3'd1: begin
               cr60_in = qq59_ff;  cg60_in = val59_ff; cb60_in = pq59_ff;
            end
            3'd2: begin
               cr60_in = pq59_ff;  cg60_in = val59_ff; cb60_in = tt59_ff;
            end
            3'd3: begin
               cr60_in = pq59_ff;  cg60_in = qq59_ff;  cb60_in = val59_ff;
            end
            3'd4: begin
               cr60_in = tt59_ff;  cg60_in = pq59_ff;  cb60_in = val59_ff;
            end
            default: begin
               cr60_in = val59_ff; cg60_in = pq59_ff;  cb60_in = qq59_ff;
            end
         endcase
      end

      rsp_in.red   = 8'((33'(cr60_ff) * 33'd255) >> 24);
      rsp_in.green = 8'((33'(cg60_ff) * 33'd255) >> 24);
      rsp_in.blue  = 8'((33'(cb60_ff) * 33'd255) >> 24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff   <= etsp_pkg::PIXEL_SCALE_RST;
         ci_ff   <= etsp_pkg::COLOR_INTENSITY_RST;
         busy_ff <= 1'b1;
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               etsp_pkg::CSR_PIXEL_SCALE:     ps_ff <= csr_wdata;
               etsp_pkg::CSR_COLOR_INTENSITY: ci_ff <= $signed(csr_wdata[15:0]);
            endcase
         end
         vld_ff[0] <= start & ~busy_ff;
         for (int k = 1; k <= LAST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_data;
      ps0_ff  <= ps_ff;
      azr1_ff <= azr1_in;
      azi1_ff <= azi1_in;
      adr1_ff <= adr1_in;
      adi1_ff <= adi1_in;
      zr2_ff  <= 64'(azr1_ff) * 64'(azr1_ff);
      zi2_ff  <= 64'(azi1_ff) * 64'(azi1_ff);
      pd2_ff  <= etsp_pkg::msb64(64'(adr1_ff | adi1_ff));
      adr2_ff <= adr1_ff;
      adi2_ff <= adi1_ff;
      z2_3_ff <= zr2_ff + zi2_ff;
      adr3_ff <= 31'(adr2_ff >> sh_c);
      adi3_ff <= 31'(adi2_ff >> sh_c);
      dr4_ff  <= 62'(adr3_ff) * 62'(adr3_ff);
      di4_ff  <= 62'(adi3_ff) * 62'(adi3_ff);
      d2_5_ff <= 63'(dr4_ff) + 63'(di4_ff);
      lnz9_ff <= lnz9_in;
      adw16_ff <= adw16_in;
      for (int k = 0; k <= SIDE_LAST; k++) begin
         side_ff[k] <= side_in[k];
      end
      for (int j = 0; j <= SQ_STEPS; j++) begin
         sq_ff[j] <= sq_in[j];
      end
      val56_ff   <= val56_in;
      sat56_ff   <= rad56[23:0];
      hfrac56_ff <= hfrac56_in;
      val57_ff   <= val56_ff;
      sat57_ff   <= sat56_ff;
      sec57_ff   <= six[26:24];
      f57_ff     <= six[23:0];
      sf58_ff    <= sf58_in;
      sf1_58_ff  <= sf1_58_in;
      pq58_ff    <= pq58_in;
      val58_ff   <= val57_ff;
      sec58_ff   <= sec57_ff;
      satz58_ff  <= (sat57_ff == '0);
      qq59_ff    <= qq59_in;
      tt59_ff    <= tt59_in;
      pq59_ff    <= pq58_ff;
      val59_ff   <= val58_ff;
      sec59_ff   <= sec58_ff;
      satz59_ff  <= satz58_ff;
      cr60_ff    <= cr60_in;
      cg60_ff    <= cg60_in;
      cb60_ff    <= cb60_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/etsp_checker.sv -----
// Port-level checker for the smooth escape-time pixel colouring block
`include "assert_macros.svh"

module etsp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   `ETSP_ASSERT_ALWAYS(a_strobe_clear_after_reset, $past(reset) |-> !rsp_valid, "strobe after reset")
   `ETSP_ASSERT_ALWAYS(a_never_busy, !reset && !$past(reset) |-> !busy, "busy outside reset")
   `ETSP_ASSERT(a_beat_has_source, rsp_valid |-> $past(start && !busy, etsp_pkg::LATENCY), "beat without pixel")

endmodule

bind escape_time_smooth_pixel_color etsp_checker u_etsp_checker (.*);
